FILE: src/mtp_pkg.sv
// ----------------------------------------------------------------------------
// Maintenance transition probability package
// Shared constants, operation and register codes, reciprocal table.
// ----------------------------------------------------------------------------
`default_nettype none

package mtp_pkg;

  localparam int MAX_COMPONENTS_DEF = 8;
  localparam int MAX_STAGES_DEF     = 8;

  localparam int IDX_W   = 24;
  localparam int PROB_W  = 32;
  localparam int CFG_W   = 4;
  localparam int RECIP_W = 28;
  localparam int SUM_W   = 36;

  localparam logic [PROB_W-1:0] Q_ONE = 32'h8000_0000;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_COMPONENT_COUNT = 1'b0;
  localparam logic REG_STAGE_COUNT     = 1'b1;

  // floor(2^RECIP_W / radix) for the radices in use
  function automatic logic [RECIP_W-1:0] recip(input logic [CFG_W-1:0] radix);
    logic [RECIP_W-1:0] r;
    case (radix)
      4'd2:    r = 28'd134217728;
      4'd3:    r = 28'd89478485;
      4'd4:    r = 28'd67108864;
      4'd5:    r = 28'd53687091;
      4'd6:    r = 28'd44739242;
      4'd7:    r = 28'd38347922;
      4'd8:    r = 28'd33554432;
      4'd9:    r = 28'd29826161;
      4'd10:   r = 28'd26843545;
      4'd11:   r = 28'd24403223;
      4'd12:   r = 28'd22369621;
      4'd13:   r = 28'd20648881;
      4'd14:   r = 28'd19173961;
      4'd15:   r = 28'd17895697;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/maintenance_transition_probability.sv
// ----------------------------------------------------------------------------
// Maintenance transition probability
// Per-component step probability table with a microcoded query engine.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       input      in_valid_i/in_ready_o   opcode, component, stage_step,
//                                              entry_value, current_index,
//                                              action_mask, next_index
//  out      output     out_valid_o/out_ready_i probability, index_error
//  cfg      input      cfg_we_i                cfg_index_i, cfg_data_i
//
//  A query handles the components one at a time through the single table
//  read port. A kept component whose level would drop skips the sum step, and
//  one at the failed level sums entries top-s to top for current level s.
//  Reset clears the table through per-entry valid bits. The result waits in
//  an output register; a new transaction is taken while it waits, and the
//  engine stalls only on a full one.
// ----------------------------------------------------------------------------
`default_nettype none

module maintenance_transition_probability #(
  parameter int MAX_COMPONENTS = mtp_pkg::MAX_COMPONENTS_DEF,
  parameter int MAX_STAGES     = mtp_pkg::MAX_STAGES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_index_i,
  input  wire logic [mtp_pkg::CFG_W-1:0]   cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        opcode_i,
  input  wire logic [2:0]                  component_i,
  input  wire logic [2:0]                  stage_step_i,
  input  wire logic [mtp_pkg::PROB_W-1:0]  entry_value_i,
  input  wire logic [mtp_pkg::IDX_W-1:0]   current_index_i,
  input  wire logic [7:0]                  action_mask_i,
  input  wire logic [mtp_pkg::IDX_W-1:0]   next_index_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [mtp_pkg::PROB_W-1:0]       probability_o,
  output logic                             index_error_o
);

  localparam int IdxW   = mtp_pkg::IDX_W;
  localparam int ProbW  = mtp_pkg::PROB_W;
  localparam int CfgW   = mtp_pkg::CFG_W;
  localparam int RecipW = mtp_pkg::RECIP_W;
  localparam int SumW   = mtp_pkg::SUM_W;
  localparam int ProdW  = IdxW + RecipW;
  localparam int CW     = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int SW     = $clog2(MAX_STAGES);
  localparam int Depth  = MAX_COMPONENTS * (1 << SW);
  localparam int AW     = CW + SW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_FIX, ST_SEL, ST_ACC, ST_MULT, ST_SHIFT, ST_DONE
  } step_e;

  typedef enum logic [2:0] {
    JC_NEVER, JC_QUERY, JC_ZERO, JC_TAIL, JC_LAST, JC_BUSY
  } cond_e;

  typedef struct packed {
    step_e nxt;
    cond_e cond;
    step_e tgt;
    logic  take;
    logic  ld_div;
    logic  ld_dig;
    logic  ld_sel;
    logic  ld_sum;
    logic  ld_prod;
    logic  ld_acc;
    logic  ld_out;
  } uop_t;

  typedef struct packed {
    logic [IdxW-1:0] quo;
    logic [3:0]      dig;
  } divres_t;

  function automatic uop_t ucode(input step_e st);
    uop_t u;
    u = '{nxt: ST_IDLE, cond: JC_NEVER, tgt: ST_IDLE, default: 1'b0};
    case (st)
      ST_IDLE: begin
        u.nxt = ST_IDLE; u.cond = JC_QUERY; u.tgt = ST_MUL; u.take = 1'b1;
      end
      ST_MUL: begin
        u.nxt = ST_FIX; u.ld_div = 1'b1;
      end
      ST_FIX: begin
        u.nxt = ST_SEL; u.ld_dig = 1'b1;
      end
      ST_SEL: begin
        u.nxt = ST_ACC; u.cond = JC_ZERO; u.tgt = ST_MULT; u.ld_sel = 1'b1;
      end
      ST_ACC: begin
        u.nxt = ST_MULT; u.cond = JC_TAIL; u.tgt = ST_ACC; u.ld_sum = 1'b1;
      end
      ST_MULT: begin
        u.nxt = ST_SHIFT; u.ld_prod = 1'b1;
      end
      ST_SHIFT: begin
        u.nxt = ST_MUL; u.cond = JC_LAST; u.tgt = ST_DONE; u.ld_acc = 1'b1;
      end
      ST_DONE: begin
        u.nxt = ST_IDLE; u.cond = JC_BUSY; u.tgt = ST_DONE; u.ld_out = 1'b1;
      end
      default: begin
        u.nxt = ST_IDLE;
      end
    endcase
    return u;
  endfunction

  function automatic logic [SW-1:0] to_step(input logic [3:0] v);
    logic [SW+3:0] t;
    t = {{SW{1'b0}}, v};
    return t[SW-1:0];
  endfunction

  function automatic divres_t div_fix(input logic [IdxW-1:0] x,
                                      input logic [IdxW-1:0] qe,
                                      input logic [3:0]      s);
    logic [IdxW+3:0] qs;
    logic [IdxW-1:0] rem;
    divres_t         res;
    qs  = qe * s;
    rem = x - qs[IdxW-1:0];
    if (rem >= IdxW'(s)) begin
      res.quo = qe + IdxW'(1);
      res.dig = 4'(rem - IdxW'(s));
    end else begin
      res.quo = qe;
      res.dig = rem[3:0];
    end
    return res;
  endfunction

  // configuration
  logic [CfgW-1:0] comp_cnt_q;
  logic [CfgW-1:0] stage_cnt_q;
  logic [CfgW-1:0] eff_n;
  logic [CfgW-1:0] eff_s;
  logic [CfgW-1:0] top;
  logic [CW-1:0]   last_comp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_cnt_q  <= CfgW'(1);
      stage_cnt_q <= CfgW'(2);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mtp_pkg::REG_COMPONENT_COUNT: comp_cnt_q  <= cfg_data_i;
        mtp_pkg::REG_STAGE_COUNT:     stage_cnt_q <= cfg_data_i;
        default:                      comp_cnt_q  <= comp_cnt_q;
      endcase
    end
  end

  always_comb begin
    if (comp_cnt_q == '0) begin
      eff_n = CfgW'(1);
    end else if ({1'b0, comp_cnt_q} > (CfgW + 1)'(MAX_COMPONENTS)) begin
      eff_n = CfgW'(MAX_COMPONENTS);
    end else begin
      eff_n = comp_cnt_q;
    end
    if (stage_cnt_q < CfgW'(2)) begin
      eff_s = CfgW'(2);
    end else if ({1'b0, stage_cnt_q} > (CfgW + 1)'(MAX_STAGES)) begin
      eff_s = CfgW'(MAX_STAGES);
    end else begin
      eff_s = stage_cnt_q;
    end
  end

  assign top       = eff_s - CfgW'(1);
  assign last_comp = CW'(eff_n - CfgW'(1));

  // sequencer and datapath registers
  step_e                 step_q, step_d;
  uop_t                  uop;
  logic                  jump;
  logic                  in_fire;
  logic [CW-1:0]         comp_q;
  logic [IdxW-1:0]       cur_q, nxt_q;
  logic [MAX_COMPONENTS-1:0] mask_q;
  logic [RecipW-1:0]     recip_q;
  logic [ProdW-1:0]      prod_cur_q, prod_nxt_q;
  logic [3:0]            s_dig_q, j_dig_q;
  logic [3:0]            k_q;
  logic                  tail_q;
  logic [SumW-1:0]       sum_q;
  logic [2*ProbW-1:0]    prod_q;
  logic [ProbW-1:0]      acc_q;
  logic                  out_valid_q;
  logic [ProbW-1:0]      prob_q;
  logic                  err_q;
  divres_t               cur_res, nxt_res;
  logic                  repl, zero_case, tail_case, tail_more, out_busy;
  logic [3:0]            sel_step;
  logic [ProbW-1:0]      factor;
  logic                  idx_err;

  // table memory
  logic [ProbW-1:0]      mem_q [Depth];
  logic [Depth-1:0]      valid_q;
  logic [AW-1:0]         raddr, waddr;
  logic                  we;
  logic [ProbW-1:0]      wdata;
  logic [ProbW-1:0]      rdata_q;
  logic                  rvalid_q;
  logic [CW+2:0]         comp_ext;
  logic [SW+2:0]         step_ext;

  assign uop        = ucode(step_q);
  assign in_ready_o = uop.take;
  assign in_fire    = in_valid_i && uop.take;
  assign out_busy   = out_valid_q && !out_ready_i;

  assign cur_res = div_fix(cur_q, prod_cur_q[ProdW-1 -: IdxW], eff_s);
  assign nxt_res = div_fix(nxt_q, prod_nxt_q[ProdW-1 -: IdxW], eff_s);

  assign repl      = mask_q[comp_q];
  assign zero_case = !repl && (j_dig_q < s_dig_q);
  assign tail_case = !repl && (j_dig_q == top);
  assign tail_more = tail_q && (k_q <= top);
  assign sel_step  = repl ? j_dig_q : (tail_case ? (top - s_dig_q) : (j_dig_q - s_dig_q));
  assign factor    = (sum_q > SumW'(mtp_pkg::Q_ONE)) ? mtp_pkg::Q_ONE : sum_q[ProbW-1:0];
  assign idx_err   = (cur_q != '0) || (nxt_q != '0);

  always_comb begin
    case (uop.cond)
      JC_QUERY: jump = in_fire && (opcode_i == mtp_pkg::OP_QUERY);
      JC_ZERO:  jump = zero_case;
      JC_TAIL:  jump = tail_more;
      JC_LAST:  jump = (comp_q == last_comp);
      JC_BUSY:  jump = out_busy;
      default:  jump = 1'b0;
    endcase
    step_d = jump ? uop.tgt : uop.nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_IDLE;
      comp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (in_fire && (opcode_i == mtp_pkg::OP_QUERY)) begin
        comp_q <= '0;
      end else if (uop.ld_acc && (comp_q != last_comp)) begin
        comp_q <= comp_q + CW'(1);
      end
      if (uop.ld_out && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (opcode_i == mtp_pkg::OP_QUERY)) begin
      cur_q   <= current_index_i;
      nxt_q   <= next_index_i;
      mask_q  <= action_mask_i[MAX_COMPONENTS-1:0];
      recip_q <= mtp_pkg::recip(eff_s);
      acc_q   <= mtp_pkg::Q_ONE;
    end
    if (uop.ld_div) begin
      prod_cur_q <= cur_q * recip_q;
      prod_nxt_q <= nxt_q * recip_q;
    end
    if (uop.ld_dig) begin
      cur_q   <= cur_res.quo;
      nxt_q   <= nxt_res.quo;
      s_dig_q <= cur_res.dig;
      j_dig_q <= nxt_res.dig;
    end
    if (uop.ld_sel) begin
      sum_q  <= '0;
      tail_q <= tail_case;
      k_q    <= top - s_dig_q + 4'd1;
    end
    if (uop.ld_sum) begin
      sum_q <= sum_q + SumW'(rvalid_q ? rdata_q : '0);
      if (tail_more) begin
        k_q <= k_q + 4'd1;
      end
    end
    if (uop.ld_prod) begin
      prod_q <= acc_q * factor;
    end
    if (uop.ld_acc) begin
      acc_q <= prod_q[2*ProbW-2 -: ProbW];
    end
    if (uop.ld_out && !out_busy) begin
      prob_q <= idx_err ? '0 : acc_q;
      err_q  <= idx_err;
    end
  end

  // table write and read ports
  assign comp_ext = {{CW{1'b0}}, component_i};
  assign step_ext = {{SW{1'b0}}, stage_step_i};
  assign we    = in_fire && (opcode_i == mtp_pkg::OP_LOAD)
              && ({1'b0, component_i} < 4'(MAX_COMPONENTS))
              && ({2'b0, stage_step_i} < 5'(MAX_STAGES));
  assign waddr = {comp_ext[CW-1:0], step_ext[SW-1:0]};
  assign wdata = (entry_value_i > mtp_pkg::Q_ONE) ? mtp_pkg::Q_ONE : entry_value_i;
  assign raddr = (step_q == ST_ACC) ? {comp_q, to_step(k_q)} : {comp_q, to_step(sel_step)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we) begin
      valid_q[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q  <= mem_q[raddr];
    rvalid_q <= valid_q[raddr];
  end

  assign out_valid_o   = out_valid_q;
  assign probability_o = prob_q;
  assign index_error_o = err_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && index_error_o |-> probability_o == '0)
    else $error("index error with nonzero probability");

  a_prob_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> probability_o <= mtp_pkg::Q_ONE)
    else $error("probability above one");

  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != ST_IDLE |-> acc_q <= mtp_pkg::Q_ONE)
    else $error("running product above one");

  a_comp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != ST_IDLE |-> comp_q <= last_comp)
    else $error("component counter past last component");

endmodule

`default_nettype wire

FILE: tb/tb_maintenance_transition_probability.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maintenance transition probability testbench
// Loads step probabilities and issues transition queries through the
// valid/ready input channel, predicts each query's Q1.31 product in a local
// copy of the table and registers, and checks every result in order with no
// idles, random sender idles, receiver stalls or both, over several register settings.
// ----------------------------------------------------------------------------

module tb_maintenance_transition_probability;

  typedef struct {
    logic                        opcode;
    logic [2:0]                  component;
    logic [2:0]                  stage_step;
    logic [mtp_pkg::PROB_W-1:0]  entry_value;
    logic [mtp_pkg::IDX_W-1:0]   current_index;
    logic [7:0]                  action_mask;
    logic [mtp_pkg::IDX_W-1:0]   next_index;
  } mtp_item_t;

  typedef struct {
    logic [mtp_pkg::PROB_W-1:0]  probability;
    logic                        index_error;
  } mtp_result_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic                        cfg_index_i;
  logic [mtp_pkg::CFG_W-1:0]   cfg_data_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic                        opcode_i;
  logic [2:0]                  component_i;
  logic [2:0]                  stage_step_i;
  logic [mtp_pkg::PROB_W-1:0]  entry_value_i;
  logic [mtp_pkg::IDX_W-1:0]   current_index_i;
  logic [7:0]                  action_mask_i;
  logic [mtp_pkg::IDX_W-1:0]   next_index_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [mtp_pkg::PROB_W-1:0]  probability_o;
  logic                        index_error_o;

  mtp_item_t   pending_items[$];
  mtp_result_t expected_results[$];
  mtp_item_t   drive_item;
  mtp_result_t want;

  logic [mtp_pkg::PROB_W-1:0] step_prob [mtp_pkg::MAX_COMPONENTS_DEF*mtp_pkg::MAX_STAGES_DEF];
  logic [mtp_pkg::CFG_W-1:0]  component_count_reg;
  logic [mtp_pkg::CFG_W-1:0]  stage_count_reg;

  logic        in_fire;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;
  int unsigned result_count;

  maintenance_transition_probability DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .component_i     (component_i),
    .stage_step_i    (stage_step_i),
    .entry_value_i   (entry_value_i),
    .current_index_i (current_index_i),
    .action_mask_i   (action_mask_i),
    .next_index_i    (next_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .probability_o   (probability_o),
    .index_error_o   (index_error_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned active_components();
    if (component_count_reg < 1) return 1;
    if (component_count_reg > mtp_pkg::MAX_COMPONENTS_DEF) return mtp_pkg::MAX_COMPONENTS_DEF;
    return component_count_reg;
  endfunction

  function automatic int unsigned active_stages();
    if (stage_count_reg < 2) return 2;
    if (stage_count_reg > mtp_pkg::MAX_STAGES_DEF) return mtp_pkg::MAX_STAGES_DEF;
    return stage_count_reg;
  endfunction

  function automatic int unsigned index_limit();
    int unsigned limit;
    limit = 1;
    for (int i = 0; i < active_components(); i++) limit *= active_stages();
    return limit;
  endfunction

  function automatic mtp_result_t predict_transition(
      input logic [mtp_pkg::IDX_W-1:0] cur_idx,
      input logic [7:0] mask,
      input logic [mtp_pkg::IDX_W-1:0] nxt_idx);
    int unsigned n, radix, top, cur, nxt, s, j, row;
    logic [63:0] acc, factor;
    mtp_result_t r;
    n = active_components();
    radix = active_stages();
    top = radix - 1;
    cur = cur_idx;
    nxt = nxt_idx;
    r.index_error = 1'b0;
    if (cur >= index_limit() || nxt >= index_limit()) begin
      r.probability = '0;
      r.index_error = 1'b1;
      return r;
    end
    acc = mtp_pkg::Q_ONE;
    for (int i = 0; i < n; i++) begin
      s = cur % radix;
      j = nxt % radix;
      cur = cur / radix;
      nxt = nxt / radix;
      row = i * mtp_pkg::MAX_STAGES_DEF;
      if (mask[i]) begin
        factor = step_prob[row + j];
      end else if (j < s) begin
        factor = 0;
      end else if (j < top) begin
        factor = step_prob[row + j - s];
      end else begin
        factor = 0;
        for (int k = top - s; k <= top; k++) factor += step_prob[row + k];
        if (factor > mtp_pkg::Q_ONE) factor = mtp_pkg::Q_ONE;
      end
      acc = (acc * factor) >> 31;
    end
    r.probability = acc[mtp_pkg::PROB_W-1:0];
    return r;
  endfunction

  function automatic mtp_item_t make_load(input logic [2:0] comp, input logic [2:0] step,
                                          input logic [mtp_pkg::PROB_W-1:0] value);
    mtp_item_t it;
    it.opcode        = mtp_pkg::OP_LOAD;
    it.component     = comp;
    it.stage_step    = step;
    it.entry_value   = value;
    it.current_index = 24'($urandom_range(24'hFF_FFFF));
    it.action_mask   = 8'($urandom_range(255));
    it.next_index    = 24'($urandom_range(24'hFF_FFFF));
    return it;
  endfunction

  function automatic mtp_item_t make_query(input logic [mtp_pkg::IDX_W-1:0] cur,
                                           input logic [7:0] mask,
                                           input logic [mtp_pkg::IDX_W-1:0] nxt);
    mtp_item_t it;
    it.opcode        = mtp_pkg::OP_QUERY;
    it.component     = 3'($urandom_range(7));
    it.stage_step    = 3'($urandom_range(7));
    it.entry_value   = $urandom;
    it.current_index = cur;
    it.action_mask   = mask;
    it.next_index    = nxt;
    return it;
  endfunction

  // next levels that never drop below the current ones
  function automatic logic [mtp_pkg::IDX_W-1:0] reachable_next(
      input logic [mtp_pkg::IDX_W-1:0] cur_idx);
    int unsigned radix, v, scale, d, res;
    radix = active_stages();
    v = cur_idx;
    scale = 1;
    res = 0;
    for (int i = 0; i < active_components(); i++) begin
      d = v % radix;
      v = v / radix;
      res += $urandom_range(radix - 1, d) * scale;
      scale *= radix;
    end
    return res[mtp_pkg::IDX_W-1:0];
  endfunction

  function automatic logic [mtp_pkg::IDX_W-1:0] random_index(input int unsigned limit);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 88) return 24'($urandom_range(limit - 1, 0));
    if (pick < 94 && limit <= 24'hFF_FFFF) return limit[mtp_pkg::IDX_W-1:0];
    return 24'($urandom_range(24'hFF_FFFF));
  endfunction

  function automatic mtp_item_t random_item();
    int unsigned limit, pick;
    logic [mtp_pkg::IDX_W-1:0] cur, nxt;
    logic [mtp_pkg::PROB_W-1:0] value;
    logic [7:0] mask;
    limit = index_limit();
    pick = $urandom_range(99);
    if (pick < 30) begin
      pick = $urandom_range(99);
      if (pick < 60) value = $urandom_range(mtp_pkg::Q_ONE, 0);
      else if (pick < 72) value = mtp_pkg::Q_ONE;
      else if (pick < 82) value = '0;
      else value = $urandom;
      return make_load(3'($urandom_range(7)), 3'($urandom_range(7)), value);
    end
    cur = random_index(limit);
    if (cur < limit && $urandom_range(99) < 50) nxt = reachable_next(cur);
    else nxt = random_index(limit);
    mask = ($urandom_range(99) < 25) ? 8'h00 : 8'($urandom_range(255));
    return make_query(cur, mask, nxt);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR result %0d: %s", result_count, msg);
    mismatch_count++;
  endtask

  task automatic write_register(input logic idx, input logic [mtp_pkg::CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    if (idx == mtp_pkg::REG_COMPONENT_COUNT) component_count_reg = data;
    else stage_count_reg = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [mtp_pkg::CFG_W-1:0] comps,
                           input logic [mtp_pkg::CFG_W-1:0] stages,
                           input idle_mode_e mode, input int unsigned count);
    write_register(mtp_pkg::REG_COMPONENT_COUNT, comps);
    write_register(mtp_pkg::REG_STAGE_COUNT, stages);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 58; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 58; end
      default:       begin send_idle_pct = 30; recv_stall_pct = 30; end
    endcase
    for (int i = 0; i < count; i++) pending_items.push_back(random_item());
    drain();
  endtask

  // drive the input channel
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_item = pending_items.pop_front();
        in_valid_i      <= 1'b1;
        opcode_i        <= drive_item.opcode;
        component_i     <= drive_item.component;
        stage_step_i    <= drive_item.stage_step;
        entry_value_i   <= drive_item.entry_value;
        current_index_i <= drive_item.current_index;
        action_mask_i   <= drive_item.action_mask;
        next_index_i    <= drive_item.next_index;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // track accepted transactions and check results
  always @(posedge clk_i) begin
    in_fire <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (opcode_i == mtp_pkg::OP_LOAD)
        step_prob[{component_i, stage_step_i}] =
          (entry_value_i > mtp_pkg::Q_ONE) ? mtp_pkg::Q_ONE : entry_value_i;
      else
        expected_results.push_back(predict_transition(current_index_i, action_mask_i,
                                                      next_index_i));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, probability %h", probability_o));
      end else begin
        want = expected_results.pop_front();
        if (probability_o !== want.probability)
          report_mismatch($sformatf("probability %h, predicted %h", probability_o,
                                    want.probability));
        if (index_error_o !== want.index_error)
          report_mismatch($sformatf("index_error %b, predicted %b", index_error_o,
                                    want.index_error));
      end
      result_count++;
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = mtp_pkg::REG_COMPONENT_COUNT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    opcode_i = mtp_pkg::OP_LOAD;
    component_i = '0;
    stage_step_i = '0;
    entry_value_i = '0;
    current_index_i = '0;
    action_mask_i = '0;
    next_index_i = '0;
    out_ready_i = 1'b0;
    in_fire = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    result_count = 0;
    component_count_reg = 4'd1;
    stage_count_reg = 4'd2;
    for (int i = 0; i < mtp_pkg::MAX_COMPONENTS_DEF * mtp_pkg::MAX_STAGES_DEF; i++)
      step_prob[i] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: one component, two levels
    pending_items.push_back(make_query(24'd0, 8'h00, 24'd1));
    pending_items.push_back(make_load(3'd0, 3'd0, 32'hFFFF_FFFF));
    pending_items.push_back(make_load(3'd0, 3'd1, mtp_pkg::Q_ONE));
    pending_items.push_back(make_load(3'd7, 3'd7, 32'h0));
    pending_items.push_back(make_load(3'd0, 3'd7, 32'h4000_0000));
    pending_items.push_back(make_query(24'd0, 8'h00, 24'd0));
    pending_items.push_back(make_query(24'd1, 8'h00, 24'd0));
    pending_items.push_back(make_query(24'd0, 8'h00, 24'd1));
    pending_items.push_back(make_query(24'd1, 8'hFE, 24'd1));
    pending_items.push_back(make_query(24'd0, 8'hFF, 24'd1));
    pending_items.push_back(make_query(24'd2, 8'h00, 24'd0));
    pending_items.push_back(make_query(24'd0, 8'h00, 24'hFF_FFFF));
    drain();

    // full size: eight components, eight levels
    write_register(mtp_pkg::REG_COMPONENT_COUNT, 4'd8);
    write_register(mtp_pkg::REG_STAGE_COUNT, 4'd8);
    pending_items.push_back(make_load(3'd3, 3'd5, 32'h7FFF_FFFF));
    pending_items.push_back(make_load(3'd7, 3'd0, 32'h8000_0001));
    pending_items.push_back(make_load(3'd5, 3'd3, 32'h0000_0001));
    pending_items.push_back(make_query(24'hFF_FFFF, 8'h00, 24'hFF_FFFF));
    pending_items.push_back(make_query(24'h00_0000, 8'hFF, 24'hFF_FFFF));
    pending_items.push_back(make_query(24'h00_0000, 8'h00, 24'h00_0000));
    pending_items.push_back(make_query(24'h00_0000, 8'hAA, 24'h55_5555));
    pending_items.push_back(make_query(24'hFF_FFFF, 8'h00, 24'h00_0000));
    drain();

    run_phase(4'd8, 4'd8, IDLE_NONE, 46);
    run_phase(4'd1, 4'd8, IDLE_SENDER, 46);
    run_phase(4'd8, 4'd2, IDLE_RECEIVER, 46);
    run_phase(4'd3, 4'd5, IDLE_BOTH, 46);
    run_phase(4'd0, 4'd1, IDLE_NONE, 46);
    run_phase(4'd15, 4'd15, IDLE_SENDER, 46);
    run_phase(4'd2, 4'd3, IDLE_RECEIVER, 46);
    run_phase(4'd4, 4'd4, IDLE_BOTH, 46);
    run_phase(4'd9, 4'd0, IDLE_NONE, 46);
    run_phase(4'd5, 4'd6, IDLE_SENDER, 46);
    run_phase(4'd1, 4'd2, IDLE_RECEIVER, 46);
    run_phase(4'd6, 4'd7, IDLE_BOTH, 46);

    if (mismatch_count == 0) begin
      $display("maintenance_transition_probability: match");
    end else begin
      $display("maintenance_transition_probability: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("maintenance_transition_probability: mismatch");
    $finish;
  end

endmodule
